// ----- hw/rtl/wtg_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and the quarter-wave sine table function of the tone generator
package wtg_pkg;

    // output queue
    localparam int unsigned FIFO_DEPTH    = 8;
    localparam int unsigned FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

    // configuration port
    localparam int unsigned APB_ADDR_BITS = 4;
    localparam int unsigned APB_DATA_BITS = 32;

    // sine table entries in q1.15, may reach 32768
    localparam int unsigned SINE_BITS   = 17;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        REG_WAVE_SHAPE  = 2'd0,
        REG_PHASE_STEP  = 2'd1,
        REG_PEAK_LEVEL  = 2'd2,
        REG_TONE_LENGTH = 2'd3
    } t_reg_index;

    typedef enum logic [1:0] {
        SHAPE_SINE     = 2'd0,
        SHAPE_SQUARE   = 2'd1,
        SHAPE_TRIANGLE = 2'd2,
        SHAPE_SAWTOOTH = 2'd3
    } t_shape;

    // control travelling with one item between stages
    typedef struct packed {
        logic valid;
        logic last;
    } t_item_ctl;

    // sin(pi/2 * k / 2^qbits) by a fixed taylor series in q30, rounded to q1.15
    function automatic logic [SINE_BITS-1:0] sine_entry(input int unsigned k,
                                                        input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] sq;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        int          n;
        x    = (HALF_PI_Q30 * 64'(k)) >> qbits;
        sq   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (n = 1; n <= 6; n++) begin
            term = (term * sq) >> 30;
            unique case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                default: term = term / 64'd156;
            endcase
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        r = (sum + 64'd16384) >> 15;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return r[SINE_BITS-1:0];
    endfunction

endpackage

// ----- hw/rtl/wtg_ram.sv -----
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read data
module wtg_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, returns the old word on a same-edge write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/wtg_state.sv -----
`timescale 1ns / 1ps
// tone state stage: reads phase, count and running flag from ram, updates and writes back
module wtg_state #(
    parameter int unsigned PHASE_BITS = 32,
    parameter int unsigned COUNT_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_restart,
    input  logic [PHASE_BITS-1:0]  i_phase_step,
    input  logic [COUNT_BITS-1:0]  i_tone_length,
    output logic                   o_busy,
    output wtg_pkg::t_item_ctl     o_ctl,
    output logic [PHASE_BITS-1:0]  o_phase
);

    localparam int unsigned STATE_BITS = PHASE_BITS + COUNT_BITS + 1;

    logic                  r_s1_valid;
    logic                  r_s1_restart;
    logic                  r_fwd;
    logic [STATE_BITS-1:0] r_fwd_state;
    logic                  r_init;
    logic                  r_out_valid;
    logic                  r_out_last;
    logic [PHASE_BITS-1:0] r_out_phase;

    logic [STATE_BITS-1:0] w_rd_data;
    logic [STATE_BITS-1:0] w_cur;
    logic [STATE_BITS-1:0] w_next;
    logic [PHASE_BITS-1:0] n_phase;
    logic [COUNT_BITS-1:0] n_count;
    logic                  n_run;
    logic [PHASE_BITS-1:0] w_smp_phase;
    logic                  w_emit;
    logic                  w_last;

    // state word: running flag, sample count, phase
    wtg_ram #(
        .WIDTH (STATE_BITS),
        .DEPTH (1)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (1'b0),
        .i_wr_data (w_next),
        .i_rd_en   (i_accept),
        .i_rd_addr (1'b0),
        .o_rd_data (w_rd_data)
    );

    // forward the word written at the same edge as our read; zero before the first write
    assign w_cur = r_fwd ? r_fwd_state : (r_init ? w_rd_data : '0);

    // tone step
    always_comb begin
        n_phase     = w_cur[PHASE_BITS-1:0];
        n_count     = w_cur[PHASE_BITS +: COUNT_BITS];
        n_run       = w_cur[STATE_BITS-1];
        w_emit      = 1'b0;
        w_last      = 1'b0;
        if (r_s1_restart) begin
            n_phase = '0;
            n_count = '0;
            n_run   = 1'b1;
        end
        w_smp_phase = n_phase;
        if (n_run) begin
            if (n_count >= i_tone_length) begin
                // length at or below the count: stop without a sample
                n_run = 1'b0;
            end else begin
                w_emit  = 1'b1;
                w_last  = ((n_count + 1'b1) == i_tone_length);
                n_phase = n_phase + i_phase_step;
                n_count = n_count + 1'b1;
                if (w_last) begin
                    n_run = 1'b0;
                end
            end
        end
        w_next = {n_run, n_count, n_phase};
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_init      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_accept;
            r_fwd       <= r_s1_valid;
            r_init      <= r_init | r_s1_valid;
            r_out_valid <= r_s1_valid & w_emit;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_restart <= i_restart;
        end
        r_fwd_state <= w_next;
        r_out_last  <= w_last;
        r_out_phase <= w_smp_phase;
    end

    assign o_busy  = r_s1_valid;
    assign o_ctl   = '{valid: r_out_valid, last: r_out_last};
    assign o_phase = r_out_phase;

endmodule

// ----- hw/rtl/wtg_shape.sv -----
`timescale 1ns / 1ps
// waveform stage: phase to scaled operand, then multiply by the peak level
module wtg_shape #(
    parameter int unsigned PHASE_BITS         = 32,
    parameter int unsigned QUARTER_TABLE_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wtg_pkg::t_item_ctl    i_ctl,
    input  logic [PHASE_BITS-1:0] i_phase,
    input  wtg_pkg::t_shape       i_shape,
    input  logic [7:0]            i_peak,
    output wtg_pkg::t_item_ctl    o_ctl,
    output logic [7:0]            o_sample
);

    localparam int unsigned QN      = 1 << QUARTER_TABLE_BITS;
    localparam int unsigned OP_BITS = PHASE_BITS + 2;
    localparam int unsigned PR_BITS = OP_BITS + 8;

    logic [wtg_pkg::SINE_BITS-1:0] w_table [QN+1];
    logic [1:0]                    w_quad;
    logic [QUARTER_TABLE_BITS-1:0] w_idx;
    logic [QUARTER_TABLE_BITS:0]   w_tidx;
    logic [wtg_pkg::SINE_BITS-1:0] w_sine;
    logic [wtg_pkg::SINE_BITS-1:0] w_sine_off;
    logic [OP_BITS-1:0]            w_p;
    logic [OP_BITS-1:0]            w_h;
    logic [OP_BITS-1:0]            w_op;
    logic [PR_BITS-1:0]            w_prod;

    logic                          r_valid;
    logic                          r_last;
    logic [OP_BITS-1:0]            r_op;

    // quarter-wave table, constant at elaboration
    for (genvar k = 0; k <= QN; k++) begin : g_table
        assign w_table[k] = wtg_pkg::sine_entry(k, QUARTER_TABLE_BITS);
    end

    // sine lookup with quadrant folding
    assign w_quad = i_phase[PHASE_BITS-1 -: 2];
    assign w_idx  = i_phase[PHASE_BITS-3 -: QUARTER_TABLE_BITS];
    assign w_tidx = w_quad[0] ? ((QUARTER_TABLE_BITS+1)'(QN) - {1'b0, w_idx})
                              : {1'b0, w_idx};
    assign w_sine = w_table[w_tidx];
    assign w_sine_off = w_quad[1] ? (wtg_pkg::SINE_BITS'(32768) - w_sine)
                                  : (wtg_pkg::SINE_BITS'(32768) + w_sine);

    assign w_p = OP_BITS'(i_phase);
    assign w_h = OP_BITS'(1) << PHASE_BITS;

    // operand scaled so that every shape shifts down by PHASE_BITS+1
    always_comb begin
        unique case (i_shape)
            wtg_pkg::SHAPE_SINE: begin
                w_op = OP_BITS'(w_sine_off) << (PHASE_BITS - 15);
            end
            wtg_pkg::SHAPE_SQUARE: begin
                if (!i_phase[PHASE_BITS-1] || (i_phase == (PHASE_BITS'(1) << (PHASE_BITS-1))))
                begin
                    w_op = OP_BITS'(1) << (PHASE_BITS + 1);
                end else begin
                    w_op = '0;
                end
            end
            wtg_pkg::SHAPE_TRIANGLE: begin
                if (w_quad == 2'b00) begin
                    w_op = (w_p << 2) + w_h;
                end else if (w_quad != 2'b11) begin
                    w_op = (w_h + (w_h << 1)) - (w_p << 2);
                end else begin
                    w_op = (w_p << 2) - (w_h + (w_h << 1));
                end
            end
            wtg_pkg::SHAPE_SAWTOOTH: begin
                if (!w_quad[1]) begin
                    w_op = (w_p << 1) + w_h;
                end else begin
                    w_op = (w_p << 1) - w_h;
                end
            end
            default: begin
                w_op = '0;
            end
        endcase
    end

    // operand register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= i_ctl.last;
        r_op   <= w_op;
    end

    // peak level times operand, result registered in the output queue
    assign w_prod   = PR_BITS'(i_peak) * PR_BITS'(r_op);
    assign o_sample = w_prod[PHASE_BITS+8 : PHASE_BITS+1];
    assign o_ctl    = '{valid: r_valid, last: r_last};

endmodule

// ----- hw/rtl/wtg_fifo.sv -----
`timescale 1ns / 1ps
// output queue of finished samples
module wtg_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic [7:0]                       i_sample,
    input  logic                             i_last,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic [7:0]                       o_sample,
    output logic                             o_last,
    output logic [wtg_pkg::FIFO_PTR_BITS:0]  o_count
);

    logic [8:0]                        r_data [wtg_pkg::FIFO_DEPTH];
    logic [wtg_pkg::FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [wtg_pkg::FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [wtg_pkg::FIFO_PTR_BITS:0]   r_count;
    logic                              w_pop;

    assign w_pop = (r_count != '0) && !i_stall;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= {i_last, i_sample};
        end
    end

    assign o_valid  = (r_count != '0);
    assign o_sample = r_data[r_rd_ptr][7:0];
    assign o_last   = r_data[r_rd_ptr][8];
    assign o_count  = r_count;

endmodule

// ----- hw/rtl/waveform_tone_generator.sv -----
`timescale 1ns / 1ps
// top level of the direct digital synthesis tone generator
// an accepted item passes the tone state stage, the waveform operand register and the output queue
// throughput: one item per cycle while the input is not stalled; the state ram read-modify-write
// keeps pace by forwarding the word written at the same edge as the next read
// an 8-entry output queue with credit counting sets when the input stalls
// reset: synchronous, active low; clears config, tone state (phase, count, idle) and queue
module waveform_tone_generator #(
    parameter int unsigned PHASE_BITS         = 32,
    parameter int unsigned QUARTER_TABLE_BITS = 8,
    parameter int unsigned COUNT_BITS         = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_restart,
    // result items
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [7:0]                        o_sample,
    output logic                              o_last,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wtg_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [wtg_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [wtg_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);

    localparam int unsigned PEND_BITS = wtg_pkg::FIFO_PTR_BITS + 2;

    wtg_pkg::t_shape                 r_wave_shape;
    logic [31:0]                     r_phase_step;
    logic [7:0]                      r_peak_level;
    logic [23:0]                     r_tone_length;

    logic                            w_cfg_wr;
    wtg_pkg::t_reg_index             w_reg;
    logic                            w_accept;
    logic                            w_s1_busy;
    wtg_pkg::t_item_ctl              w_s2_ctl;
    logic [PHASE_BITS-1:0]           w_s2_phase;
    wtg_pkg::t_item_ctl              w_s3_ctl;
    logic [7:0]                      w_s3_sample;
    logic [wtg_pkg::FIFO_PTR_BITS:0] w_fifo_count;
    logic [PEND_BITS-1:0]            w_pending;

    // configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = wtg_pkg::t_reg_index'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_shape  <= wtg_pkg::SHAPE_SINE;
            r_phase_step  <= '0;
            r_peak_level  <= '0;
            r_tone_length <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                wtg_pkg::REG_WAVE_SHAPE:  r_wave_shape  <= wtg_pkg::t_shape'(pwdata[1:0]);
                wtg_pkg::REG_PHASE_STEP:  r_phase_step  <= pwdata;
                wtg_pkg::REG_PEAK_LEVEL:  r_peak_level  <= pwdata[7:0];
                wtg_pkg::REG_TONE_LENGTH: r_tone_length <= pwdata[23:0];
                default:                  r_wave_shape  <= r_wave_shape;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (w_reg)
            wtg_pkg::REG_WAVE_SHAPE:  prdata = 32'(r_wave_shape);
            wtg_pkg::REG_PHASE_STEP:  prdata = r_phase_step;
            wtg_pkg::REG_PEAK_LEVEL:  prdata = 32'(r_peak_level);
            wtg_pkg::REG_TONE_LENGTH: prdata = 32'(r_tone_length);
            default:                  prdata = '0;
        endcase
    end

    // credit: items in flight plus queued samples must fit the queue
    assign w_pending = PEND_BITS'(w_fifo_count) + PEND_BITS'(w_s1_busy)
                     + PEND_BITS'(w_s2_ctl.valid) + PEND_BITS'(w_s3_ctl.valid);
    assign o_in_stall = (w_pending >= PEND_BITS'(wtg_pkg::FIFO_DEPTH));
    assign w_accept   = i_in_valid && !o_in_stall;

    // tone state read-modify-write
    wtg_state #(
        .PHASE_BITS (PHASE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_restart     (i_restart),
        .i_phase_step  (PHASE_BITS'(r_phase_step)),
        .i_tone_length (COUNT_BITS'(r_tone_length)),
        .o_busy        (w_s1_busy),
        .o_ctl         (w_s2_ctl),
        .o_phase       (w_s2_phase)
    );

    // waveform and level scaling
    wtg_shape #(
        .PHASE_BITS         (PHASE_BITS),
        .QUARTER_TABLE_BITS (QUARTER_TABLE_BITS)
    ) u_shape (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_s2_ctl),
        .i_phase  (w_s2_phase),
        .i_shape  (r_wave_shape),
        .i_peak   (r_peak_level),
        .o_ctl    (w_s3_ctl),
        .o_sample (w_s3_sample)
    );

    // output queue
    wtg_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_s3_ctl.valid),
        .i_sample (w_s3_sample),
        .i_last   (w_s3_ctl.last),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_sample (o_sample),
        .o_last   (o_last),
        .o_count  (w_fifo_count)
    );

endmodule

// ----- hw/rtl/wtg_checker.sv -----
`timescale 1ns / 1ps
// port-level checks of the tone generator, bound to the top level
module wtg_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              i_restart,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [7:0]                        o_sample,
    input logic                              o_last,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [wtg_pkg::APB_ADDR_BITS-1:0] paddr,
    input logic [wtg_pkg::APB_DATA_BITS-1:0] pwdata,
    input logic [wtg_pkg::APB_DATA_BITS-1:0] prdata,
    input logic                              pready
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample) && $stable(o_last))
        else $error("result item changed under stall");

    // leaving reset the block is empty and ready
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

    // input only stalls while finished samples are backed up
    a_stall_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled without queued samples");

    // wave shape register reads back what was written
    a_shape_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && (paddr[3:2] == wtg_pkg::REG_WAVE_SHAPE))
        ##1 (paddr[3:2] == wtg_pkg::REG_WAVE_SHAPE)
        |-> prdata[1:0] == $past(pwdata[1:0]))
        else $error("wave shape read back mismatch");

endmodule

bind waveform_tone_generator wtg_checker u_checker (.*);
